// File: rtl/core/yaw_heading_velocity_rotator_unit_macros.svh
// Assertion macros for the yaw heading velocity rotator.
`ifndef YAW_HEADING_VELOCITY_ROTATOR_UNIT_MACROS_SVH
`define YAW_HEADING_VELOCITY_ROTATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define YHVR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define YHVR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/yhvr_pkg.sv
// Shared constants, types and the arctangent table of the yaw rotator.
`timescale 1ns / 1ps
package yhvr_pkg;

  localparam int WORD_W       = 16;
  localparam int DP_W         = 36;   // CORDIC x/y datapath
  localparam int ANG_W        = 34;   // CORDIC angle, 2^32 per turn
  localparam int TABLE_LEN    = 24;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_COUNT   = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int IDX_W        = $clog2(TABLE_LEN);
  localparam int ATAN_W       = 30;
  localparam int GUARD_BITS   = 14;
  localparam int MUL_A_W      = 32;
  localparam int MUL_B_W      = 31;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int FRAC_SHIFT   = 30 + GUARD_BITS;

  localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(64'h4000_0000);
  localparam logic signed [ANG_W-1:0] HALF_TURN    = ANG_W'(64'h8000_0000);
  localparam logic signed [MUL_B_W-1:0] INV_GAIN   = MUL_B_W'(652032874);

  typedef struct packed {
    logic                    load;
    logic                    vectoring;
    logic signed [DP_W-1:0]  x;
    logic signed [DP_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
  } cordic_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  // atan(2^-i), 2^32 per turn, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_turn(input logic [IDX_W-1:0] idx);
    case (idx)
      0:       atan_turn = 30'd536870912;
      1:       atan_turn = 30'd316933406;
      2:       atan_turn = 30'd167458907;
      3:       atan_turn = 30'd85004756;
      4:       atan_turn = 30'd42667331;
      5:       atan_turn = 30'd21354465;
      6:       atan_turn = 30'd10679838;
      7:       atan_turn = 30'd5340245;
      8:       atan_turn = 30'd2670163;
      9:       atan_turn = 30'd1335087;
      10:      atan_turn = 30'd667544;
      11:      atan_turn = 30'd333772;
      12:      atan_turn = 30'd166886;
      13:      atan_turn = 30'd83443;
      14:      atan_turn = 30'd41722;
      15:      atan_turn = 30'd20861;
      16:      atan_turn = 30'd10430;
      17:      atan_turn = 30'd5215;
      18:      atan_turn = 30'd2608;
      19:      atan_turn = 30'd1304;
      20:      atan_turn = 30'd652;
      21:      atan_turn = 30'd326;
      22:      atan_turn = 30'd163;
      23:      atan_turn = 30'd81;
      default: atan_turn = '0;
    endcase
  endfunction

endpackage

// File: rtl/core/yaw_heading_velocity_rotator_unit.sv
// Yaw heading velocity rotator: quaternion yaw to heading, velocity frame rotation.
// Velocity word: the result is loaded into the output register in FIN_W, which waits while
// that register is still full; the next word is taken only after that, back in IDLE.
// Orientation word: no result; the CORDIC is skipped if the yaw vector is 0/0.
// Rate is set by the single shared CORDIC stage and the one shared multiplier.
// Synchronous reset clears the heading to zero and empties the output register.
`timescale 1ns / 1ps
`include "yaw_heading_velocity_rotator_unit_macros.svh"
module yaw_heading_velocity_rotator_unit import yhvr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     mode,
  input  logic signed [WORD_W-1:0] quat_w,
  input  logic signed [WORD_W-1:0] quat_x,
  input  logic signed [WORD_W-1:0] quat_y,
  input  logic signed [WORD_W-1:0] quat_z,
  input  logic signed [WORD_W-1:0] body_vel_x,
  input  logic signed [WORD_W-1:0] body_vel_y,
  input  logic signed [WORD_W-1:0] body_vel_z,
  input  logic signed [WORD_W-1:0] turn_rate,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] world_vel_x,
  output logic signed [WORD_W-1:0] world_vel_y,
  output logic signed [WORD_W-1:0] out_vel_z,
  output logic signed [WORD_W-1:0] out_turn_rate
);

  typedef enum logic [3:0] {
    IDLE, Q_WZ, Q_XY, Q_YY, Q_ZZ, Q_DEN, Q_PRE, VEC_RUN, HEAD,
    ROT_LOAD, ROT_RUN, FIN_X, FIN_Y, FIN_W
  } state_t;

  localparam int SUM_W = 2 * WORD_W + 1;
  localparam int Q_W   = PROD_W - FRAC_SHIFT;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_SHIFT - 1);
  localparam logic signed [Q_W-1:0]    Q_MAX = Q_W'((2 ** (WORD_W - 1)) - 1);
  localparam logic signed [Q_W-1:0]    Q_MIN = -Q_W'(2 ** (WORD_W - 1));

  state_t                    state;
  logic signed [WORD_W-1:0]  qw, qx, qy, qz, vx, vy, vz, tr;
  logic signed [SUM_W-1:0]   acc, num_sum, sq_sum, prod_lo;
  logic signed [ANG_W-1:0]   num_r, den_r, den_calc, psi, h34, rz0;
  logic                      zero_vec, psi_zero;
  logic [WORD_W-1:0]         heading;
  logic signed [WORD_W-1:0]  tmp_x;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [31:0]               a32;
  logic [32:0]               h_round;
  logic signed [DP_W-1:0]    vx_g, vy_g;
  cordic_cmd_t               cmd;
  cordic_stat_t              cstat;
  logic signed [DP_W-1:0]    cx, cy;
  logic signed [ANG_W-1:0]   cz;

  yhvr_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .stat  (cstat),
    .x_out (cx),
    .y_out (cy),
    .z_out (cz)
  );

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    logic signed [Q_W-1:0]    q;
    r = p + ROUND_HALF;
    q = r[PROD_W-1:FRAC_SHIFT];
    if (q > Q_MAX)      sat_word = Q_MAX[WORD_W-1:0];
    else if (q < Q_MIN) sat_word = Q_MIN[WORD_W-1:0];
    else                sat_word = q[WORD_W-1:0];
  endfunction

  assign in_ready = (state == IDLE);

  // shared multiplier operands
  always_comb begin
    case (state)
      Q_WZ:    begin mul_a = MUL_A_W'(qw); mul_b = MUL_B_W'(qz); end
      Q_XY:    begin mul_a = MUL_A_W'(qx); mul_b = MUL_B_W'(qy); end
      Q_YY:    begin mul_a = MUL_A_W'(qy); mul_b = MUL_B_W'(qy); end
      Q_ZZ:    begin mul_a = MUL_A_W'(qz); mul_b = MUL_B_W'(qz); end
      FIN_Y,
      FIN_W:   begin mul_a = cy[MUL_A_W-1:0]; mul_b = INV_GAIN; end
      default: begin mul_a = cx[MUL_A_W-1:0]; mul_b = INV_GAIN; end
    endcase
  end

  always_comb begin
    prod_lo  = $signed(prod[SUM_W-1:0]);
    sq_sum   = acc + prod_lo;
    den_calc = QUARTER_TURN - $signed({sq_sum, 1'b0});
    zero_vec = (num_r == '0) && (den_r == '0);

    psi     = psi_zero ? '0 : cz;
    h34     = QUARTER_TURN - psi;
    h_round = {1'b0, h34[31:0]} + 33'h8000;

    // rotation angle is minus the heading, folded into +-90 degrees
    a32  = 32'd0 - {heading, 16'h0000};
    rz0  = ANG_W'($signed(a32));
    vx_g = DP_W'(vx) <<< GUARD_BITS;
    vy_g = DP_W'(vy) <<< GUARD_BITS;

    cmd.load      = 1'b0;
    cmd.vectoring = 1'b0;
    cmd.x         = vx_g;
    cmd.y         = vy_g;
    cmd.z         = rz0;
    case (state)
      Q_PRE: begin
        cmd.load      = ~zero_vec;
        cmd.vectoring = 1'b1;
        if (den_r[ANG_W-1]) begin
          if (!num_r[ANG_W-1]) begin
            cmd.x = DP_W'(num_r);
            cmd.y = -DP_W'(den_r);
            cmd.z = QUARTER_TURN;
          end else begin
            cmd.x = -DP_W'(num_r);
            cmd.y = DP_W'(den_r);
            cmd.z = -QUARTER_TURN;
          end
        end else begin
          cmd.x = DP_W'(den_r);
          cmd.y = DP_W'(num_r);
          cmd.z = '0;
        end
      end
      ROT_LOAD: begin
        cmd.load = 1'b1;
        if (rz0 > QUARTER_TURN) begin
          cmd.x = -vx_g;
          cmd.y = -vy_g;
          cmd.z = rz0 - HALF_TURN;
        end else if (rz0 < -QUARTER_TURN) begin
          cmd.x = -vx_g;
          cmd.y = -vy_g;
          cmd.z = rz0 + HALF_TURN;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state     <= IDLE;
      heading   <= '0;
      out_valid <= 1'b0;
    end else begin
      // FIN_W decides on its own whether the output register reloads
      if (out_valid && out_ready && (state != FIN_W)) out_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (in_valid) begin
            qw <= quat_w;
            qx <= quat_x;
            qy <= quat_y;
            qz <= quat_z;
            vx <= body_vel_x;
            vy <= body_vel_y;
            vz <= body_vel_z;
            tr <= turn_rate;
            state <= mode ? ROT_LOAD : Q_WZ;
          end
        end
        Q_WZ: state <= Q_XY;
        Q_XY: begin
          acc   <= prod_lo;
          state <= Q_YY;
        end
        Q_YY: begin
          num_sum <= acc + prod_lo;
          state   <= Q_ZZ;
        end
        Q_ZZ: begin
          acc   <= prod_lo;
          state <= Q_DEN;
        end
        Q_DEN: begin
          num_r <= $signed({num_sum, 1'b0});
          den_r <= den_calc;
          state <= Q_PRE;
        end
        Q_PRE: begin
          // zero yaw vector: psi is zero, skip the CORDIC
          psi_zero <= zero_vec;
          state    <= zero_vec ? HEAD : VEC_RUN;
        end
        VEC_RUN: if (cstat.done) state <= HEAD;
        HEAD: begin
          heading <= h_round[31:16];
          state   <= IDLE;
        end
        ROT_LOAD: state <= ROT_RUN;
        ROT_RUN:  if (cstat.done) state <= FIN_X;
        FIN_X:    state <= FIN_Y;
        FIN_Y: begin
          tmp_x <= sat_word(prod);
          state <= FIN_W;
        end
        FIN_W: begin
          // hold here until the output register is free
          if (!out_valid || out_ready) begin
            world_vel_x   <= tmp_x;
            world_vel_y   <= sat_word(prod);
            out_vel_z     <= vz;
            out_turn_rate <= tr;
            out_valid     <= 1'b1;
            state         <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `YHVR_ASSERT_IMP(a_idle_cordic_free, in_ready, !cstat.busy, "cordic busy while taking a word")
  `YHVR_ASSERT_IMP(a_done_in_wait, cstat.done, (state == VEC_RUN) || (state == ROT_RUN), "cordic done outside a wait state")
  `YHVR_ASSERT_NXT(a_orient_no_result, in_valid && in_ready && !mode && !out_valid, !out_valid, "orientation word produced a result")

endmodule

// File: rtl/core/yhvr_cordic.sv
// Iterative CORDIC: one micro-rotation per cycle, vectoring or rotation mode.
`timescale 1ns / 1ps
module yhvr_cordic import yhvr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cordic_cmd_t             cmd,
  output cordic_stat_t            stat,
  output logic signed [DP_W-1:0]  x_out,
  output logic signed [DP_W-1:0]  y_out,
  output logic signed [ANG_W-1:0] z_out
);

  logic signed [DP_W-1:0]  x, y, x_next, y_next, xs, ys;
  logic signed [ANG_W-1:0] z, z_next, at;
  logic [IDX_W-1:0]        cnt;
  logic                    vec, busy, done, up;

  always_comb begin
    xs = x >>> cnt;
    ys = y >>> cnt;
    at = $signed({{(ANG_W-ATAN_W){1'b0}}, atan_turn(cnt)});
    // vectoring drives y toward zero, rotation drives z toward zero
    up = vec ? ~y[DP_W-1] : z[ANG_W-1];
    x_next = up ? x + ys : x - ys;
    y_next = up ? y - xs : y + xs;
    z_next = up ? z + at : z - at;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (cmd.load) begin
        x    <= cmd.x;
        y    <= cmd.y;
        z    <= cmd.z;
        vec  <= cmd.vectoring;
        cnt  <= '0;
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy) begin
        x <= x_next;
        y <= y_next;
        z <= z_next;
        if (cnt == IDX_W'(STEP_COUNT - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt  <= cnt + 1'b1;
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign x_out     = x;
  assign y_out     = y;
  assign z_out     = z;

endmodule

// File: tb/yaw_rotation_checker.sv
// Checker for the yaw rotator: tracks the heading, predicts world velocity words, compares them.
`timescale 1ns / 1ps
module yaw_rotation_checker import yhvr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     mode,
  input  logic signed [WORD_W-1:0] quat_w,
  input  logic signed [WORD_W-1:0] quat_x,
  input  logic signed [WORD_W-1:0] quat_y,
  input  logic signed [WORD_W-1:0] quat_z,
  input  logic signed [WORD_W-1:0] body_vel_x,
  input  logic signed [WORD_W-1:0] body_vel_y,
  input  logic signed [WORD_W-1:0] body_vel_z,
  input  logic signed [WORD_W-1:0] turn_rate,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [WORD_W-1:0] world_vel_x,
  input  logic signed [WORD_W-1:0] world_vel_y,
  input  logic signed [WORD_W-1:0] out_vel_z,
  input  logic signed [WORD_W-1:0] out_turn_rate,
  output int                       mismatches,
  output int                       pending
);

  localparam longint QTR_TURN  = 64'sd1073741824;
  localparam longint HALF_REV  = 64'sd2147483648;
  localparam longint FULL_REV  = 64'sd4294967296;
  localparam longint GAIN_COMP = 64'sd652032874;

  typedef struct packed {
    logic signed [WORD_W-1:0] vx;
    logic signed [WORD_W-1:0] vy;
    logic signed [WORD_W-1:0] vz;
    logic signed [WORD_W-1:0] rate;
  } world_word_t;

  world_word_t       expected_world [$];
  logic [WORD_W-1:0] heading;
  int                fails;

  // atan(2^-i) with 2^32 per turn
  function automatic longint micro_angle(input int i);
    case (i)
      0:       return 536870912;
      1:       return 316933406;
      2:       return 167458907;
      3:       return 85004756;
      4:       return 42667331;
      5:       return 21354465;
      6:       return 10679838;
      7:       return 5340245;
      8:       return 2670163;
      9:       return 1335087;
      10:      return 667544;
      11:      return 333772;
      12:      return 166886;
      13:      return 83443;
      14:      return 41722;
      15:      return 20861;
      16:      return 10430;
      17:      return 5215;
      18:      return 2608;
      19:      return 1304;
      20:      return 652;
      21:      return 326;
      22:      return 163;
      default: return 81;
    endcase
  endfunction

  function automatic longint yaw_vector_angle(input longint num, input longint den);
    longint x, y, z, t;
    int     i;
    x = den;
    y = num;
    z = 0;
    if (num == 0 && den == 0) return 0;
    // pre-rotate by a quarter turn when the vector points backwards
    if (den < 0) begin
      if (num >= 0) begin
        x = num;
        y = -den;
        z = QTR_TURN;
      end else begin
        x = -num;
        y = den;
        z = -QTR_TURN;
      end
    end
    for (i = 0; i < STEP_COUNT; i++) begin
      if (y >= 0) begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        x = t;
        z += micro_angle(i);
      end else begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        x = t;
        z -= micro_angle(i);
      end
    end
    return z;
  endfunction

  function automatic logic [WORD_W-1:0] heading_of_quat(input logic signed [WORD_W-1:0] qw,
      input logic signed [WORD_W-1:0] qx, input logic signed [WORD_W-1:0] qy,
      input logic signed [WORD_W-1:0] qz);
    longint w, x, y, z, num, den, h32;
    w = qw;
    x = qx;
    y = qy;
    z = qz;
    num = 2 * (w * z + x * y);
    den = QTR_TURN - 2 * (y * y + z * z);
    h32 = (QTR_TURN - yaw_vector_angle(num, den)) & 64'h0000_0000_FFFF_FFFF;
    return WORD_W'((h32 + 64'sd32768) >> 16);
  endfunction

  function automatic logic signed [WORD_W-1:0] round_sat(input longint v);
    longint r;
    r = (v * GAIN_COMP + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return WORD_W'(r);
  endfunction

  function automatic world_word_t rotate_to_world(input logic [WORD_W-1:0] hdg,
      input logic signed [WORD_W-1:0] vx, input logic signed [WORD_W-1:0] vy,
      input logic signed [WORD_W-1:0] vz, input logic signed [WORD_W-1:0] rate);
    world_word_t w;
    longint      x, y, z, t;
    int          i;
    x = longint'(vx) <<< GUARD_BITS;
    y = longint'(vy) <<< GUARD_BITS;
    // rotate by -heading, folded into [-half, half)
    z = -(longint'(hdg) <<< 16);
    if (z < -HALF_REV) z += FULL_REV;
    if (z > QTR_TURN) begin
      x = -x;
      y = -y;
      z -= HALF_REV;
    end else if (z < -QTR_TURN) begin
      x = -x;
      y = -y;
      z += HALF_REV;
    end
    for (i = 0; i < STEP_COUNT; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        x = t;
        z -= micro_angle(i);
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        x = t;
        z += micro_angle(i);
      end
    end
    w.vx   = round_sat(x);
    w.vy   = round_sat(y);
    w.vz   = vz;
    w.rate = rate;
    return w;
  endfunction

  task automatic flag(input string what, input logic signed [WORD_W-1:0] want,
      input logic signed [WORD_W-1:0] got);
    fails++;
    if (fails <= 10)
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    world_word_t want;
    if (rst) begin
      heading = '0;
      expected_world.delete();
      fails = 0;
    end else begin
      // retire before predicting: a word accepted now cannot leave in the same cycle
      if (out_valid && out_ready) begin
        if (expected_world.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t ns: unexpected result word %0d %0d %0d %0d", $time,
                     world_vel_x, world_vel_y, out_vel_z, out_turn_rate);
        end else begin
          want = expected_world.pop_front();
          if (world_vel_x !== want.vx) flag("world_vel_x", want.vx, world_vel_x);
          if (world_vel_y !== want.vy) flag("world_vel_y", want.vy, world_vel_y);
          if (out_vel_z !== want.vz) flag("out_vel_z", want.vz, out_vel_z);
          if (out_turn_rate !== want.rate) flag("out_turn_rate", want.rate, out_turn_rate);
        end
      end
      if (in_valid && in_ready) begin
        if (mode == 1'b0)
          heading = heading_of_quat(quat_w, quat_x, quat_y, quat_z);
        else
          expected_world.push_back(rotate_to_world(heading, body_vel_x, body_vel_y,
                                                   body_vel_z, turn_rate));
      end
    end
    mismatches <= fails;
    pending    <= expected_world.size();
  end

endmodule

// File: tb/tb_yaw_heading_velocity_rotator_unit.sv
// Testbench top for the yaw rotator: clock, reset, word stimulus, output stalls and verdict.
`timescale 1ns / 1ps
module tb_yaw_heading_velocity_rotator_unit;
  import yhvr_pkg::*;

  localparam int RANDOM_WORDS = 400;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam logic MODE_ORIENT = 1'b0;
  localparam logic MODE_VEL    = 1'b1;

  typedef struct {
    logic                     mode;
    logic signed [WORD_W-1:0] qw, qx, qy, qz;
    logic signed [WORD_W-1:0] vx, vy, vz, wr;
  } cmd_word_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic                     mode;
  logic signed [WORD_W-1:0] quat_w, quat_x, quat_y, quat_z;
  logic signed [WORD_W-1:0] body_vel_x, body_vel_y, body_vel_z, turn_rate;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [WORD_W-1:0] world_vel_x, world_vel_y, out_vel_z, out_turn_rate;
  int                       mismatches;
  int                       pending;
  int                       cycle_cnt = 0;
  bit                       in_idle_on = 1'b1;
  bit                       out_idle_on = 1'b1;

  yaw_heading_velocity_rotator_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .body_vel_x(body_vel_x), .body_vel_y(body_vel_y), .body_vel_z(body_vel_z),
    .turn_rate(turn_rate),
    .out_valid(out_valid), .out_ready(out_ready),
    .world_vel_x(world_vel_x), .world_vel_y(world_vel_y),
    .out_vel_z(out_vel_z), .out_turn_rate(out_turn_rate)
  );

  yaw_rotation_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .body_vel_x(body_vel_x), .body_vel_y(body_vel_y), .body_vel_z(body_vel_z),
    .turn_rate(turn_rate),
    .out_valid(out_valid), .out_ready(out_ready),
    .world_vel_x(world_vel_x), .world_vel_y(world_vel_y),
    .out_vel_z(out_vel_z), .out_turn_rate(out_turn_rate),
    .mismatches(mismatches), .pending(pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic signed [WORD_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [WORD_W-1:0] near_zero();
    return WORD_W'($urandom_range(0, 64) - 32);
  endfunction

  // unused fields of a word still carry random bits
  function automatic cmd_word_t orient_word(input int w, input int x, input int y, input int z);
    cmd_word_t c;
    c.mode = MODE_ORIENT;
    c.qw = WORD_W'(w);
    c.qx = WORD_W'(x);
    c.qy = WORD_W'(y);
    c.qz = WORD_W'(z);
    c.vx = WORD_W'($urandom);
    c.vy = WORD_W'($urandom);
    c.vz = WORD_W'($urandom);
    c.wr = WORD_W'($urandom);
    return c;
  endfunction

  function automatic cmd_word_t vel_word(input int vx, input int vy, input int vz, input int wr);
    cmd_word_t c;
    c = orient_word($urandom, $urandom, $urandom, $urandom);
    c.mode = MODE_VEL;
    c.vx = WORD_W'(vx);
    c.vy = WORD_W'(vy);
    c.vz = WORD_W'(vz);
    c.wr = WORD_W'(wr);
    return c;
  endfunction

  function automatic cmd_word_t rand_word();
    cmd_word_t c;
    c = vel_word($urandom, $urandom, $urandom, $urandom);
    c.mode = ($urandom_range(0, 9) < 6) ? MODE_VEL : MODE_ORIENT;
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        // pure yaw quaternion
        c.qx = '0;
        c.qy = '0;
      end
      2: begin
        c.qw = near_zero();
        c.qx = near_zero();
        c.qy = near_zero();
        c.qz = near_zero();
      end
      default: begin
        c.qw = '0;
        c.qx = near_zero();
        c.qy = '0;
        c.qz = ($urandom_range(0, 1) == 0) ? '0 : near_zero();
      end
    endcase
    if ($urandom_range(0, 5) == 0) begin
      c.vx = pick_extreme();
      c.vy = pick_extreme();
      c.vz = pick_extreme();
      c.wr = pick_extreme();
    end
    return c;
  endfunction

  task automatic send_word(input cmd_word_t c);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= c.mode;
    quat_w     <= c.qw;
    quat_x     <= c.qx;
    quat_y     <= c.qy;
    quat_z     <= c.qz;
    body_vel_x <= c.vx;
    body_vel_y <= c.vy;
    body_vel_z <= c.vz;
    turn_rate  <= c.wr;
    do @(posedge clk); while (!in_ready);
  endtask

  // result side: random stalls, two long hold-offs to back the block up
  initial begin
    int gap;
    int taken;
    out_ready = 1'b0;
    taken = 0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (taken % 40 == 0) out_idle_on = ($urandom_range(0, 3) != 0);
      gap = out_idle_on ? $urandom_range(0, 14) : 0;
      if (taken == 30 || taken == 200) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    cmd_word_t directed [$];
    int        n;
    rst        = 1'b1;
    in_valid   = 1'b0;
    mode       = MODE_ORIENT;
    quat_w     = '0;
    quat_x     = '0;
    quat_y     = '0;
    quat_z     = '0;
    body_vel_x = '0;
    body_vel_y = '0;
    body_vel_z = '0;
    turn_rate  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // heading zero after reset
    directed.push_back(vel_word(32767, -32768, 32767, -32768));
    directed.push_back(vel_word(-32768, 32767, -32768, 32767));
    // identity orientation gives a quarter-turn heading
    directed.push_back(orient_word(32767, 0, 0, 0));
    directed.push_back(vel_word(12345, -2222, 1, -1));
    // all-zero quaternion: numerator zero, denominator a quarter turn
    directed.push_back(orient_word(0, 0, 0, 0));
    directed.push_back(vel_word(32767, 32767, 0, 0));
    // 45 degree yaw, rotated outputs saturate
    directed.push_back(orient_word(30273, 0, 0, 12539));
    directed.push_back(vel_word(32767, 32767, 5, -5));
    directed.push_back(vel_word(-32768, -32768, -7, 7));
    directed.push_back(vel_word(32767, -32768, 0, 0));
    // backwards yaw vector, numerator zero
    directed.push_back(orient_word(0, 0, 0, 32767));
    directed.push_back(vel_word(1000, 2000, 3000, 4000));
    // backwards yaw vector, numerator negative
    directed.push_back(orient_word(10000, 0, 0, -30000));
    directed.push_back(vel_word(-5000, 7000, 1, 2));
    directed.push_back(orient_word(-32768, -32768, -32768, -32768));
    directed.push_back(vel_word(32767, 1, -1, 0));
    // non-unit quaternion
    directed.push_back(orient_word(100, 0, 0, 100));
    directed.push_back(vel_word(-20000, -100, 0, 32767));
    directed.push_back(orient_word(0, 32767, 32767, 0));
    directed.push_back(vel_word(0, 0, -32768, 32767));
    // yaw of -90 degrees puts the rotation at a half turn
    directed.push_back(orient_word(23170, 0, 0, -23170));
    directed.push_back(vel_word(20000, -20000, 32767, -32768));
    foreach (directed[i]) send_word(directed[i]);

    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) in_idle_on = ($urandom_range(0, 3) != 0);
      send_word(rand_word());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/yhvr_pkg.sv
rtl/core/yhvr_cordic.sv
rtl/core/yaw_heading_velocity_rotator_unit.sv
tb/yaw_rotation_checker.sv
tb/tb_yaw_heading_velocity_rotator_unit.sv
